[hdl/mbt_pkg.sv]
// ============================================================================
// mbt_pkg
// Shared types, constants and helpers for the multibit trie prefix lookup.
// ============================================================================
package mbt_pkg;

    // Trie geometry
    localparam int STRIDE    = 8;
    localparam int NODES     = 256;
    localparam int FANOUT    = 1 << STRIDE;
    localparam int LEVELS    = 32 / STRIDE;
    localparam int CHILD_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int FREE_W    = $clog2(NODES + 1);
    localparam int DEPTH_W   = $clog2(LEVELS + 1);
    localparam int ADDR_W    = CHILD_W + STRIDE;
    localparam int MEM_DEPTH = NODES * FANOUT;

    // Stream widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STAT_OK        = 2'd0,
        STAT_BAD_LEN   = 2'd1,
        STAT_POOL_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } eng_state_t;

    // One node pool entry
    typedef struct packed
    {
        logic               valid;
        logic [31:0]        hop;
        logic [CHILD_W-1:0] child;
    } entry_t;

    // Single-port request into the node pool
    typedef struct packed
    {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        entry_t            wdata;
    } ram_req_t;

    typedef struct packed
    {
        op_t         opcode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] hop_in;
    } cmd_t;

    typedef struct packed
    {
        logic        hit;
        logic [31:0] hop_out;
        status_t     status;
    } res_t;

    // Map a prefix length to its trie depth; zero marks a bad length
    function automatic logic [DEPTH_W-1:0] len_depth(input logic [5:0] len);
        logic [DEPTH_W-1:0] depth;
        depth = '0;
        for (int d = 1; d <= LEVELS; d++)
        begin
            if (len == 6'(d * STRIDE))
            begin
                depth = DEPTH_W'(d);
            end
        end
        return depth;
    endfunction

endpackage

[hdl/mbt_node_ram.sv]
// ============================================================================
// mbt_node_ram
// Single-port node pool memory with registered read data.
// ============================================================================
module mbt_node_ram
    import mbt_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rdata
);

    entry_t mem [MEM_DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

[hdl/mbt_engine.sv]
// ============================================================================
// mbt_engine
// Sequencer that walks the trie one level per read, allocates nodes on
// insert and tracks the deepest valid hop on lookup.
// ============================================================================
module mbt_engine
    import mbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  cmd_t     cmd,
    output logic     cmd_ready,
    output logic     res_valid,
    output res_t     res,
    input  logic     res_ready,
    output ram_req_t ram_req,
    input  entry_t   ram_rdata
);

    eng_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    op_t                 op_reg, op_next;
    logic [31:0]         addr_reg, addr_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [DEPTH_W-1:0]  level_reg, level_next;
    logic [CHILD_W-1:0]  node_reg, node_next;
    logic [31:0]         hop_in_reg, hop_in_next;
    logic                hit_reg, hit_next;
    logic [31:0]         hop_out_reg, hop_out_next;
    status_t             status_reg, status_next;

    logic [DEPTH_W-1:0]  cmd_depth;
    logic [ADDR_W-1:0]   walk_addr;
    logic [FREE_W:0]     need_total;

    assign cmd_depth = len_depth(cmd.prefix_len);
    assign walk_addr = {node_reg, addr_reg[31 -: STRIDE]};
    assign need_total = {1'b0, free_reg}
                      + (FREE_W + 1)'(depth_reg - level_reg - DEPTH_W'(1));

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            free_reg  <= FREE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
        end
    end

    // Hold the working item
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        depth_reg   <= depth_next;
        level_reg   <= level_next;
        node_reg    <= node_next;
        hop_in_reg  <= hop_in_next;
        hit_reg     <= hit_next;
        hop_out_reg <= hop_out_next;
        status_reg  <= status_next;
    end

    // Sequence the walk
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        free_next    = free_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        depth_next   = depth_reg;
        level_next   = level_reg;
        node_next    = node_reg;
        hop_in_next  = hop_in_reg;
        hit_next     = hit_reg;
        hop_out_next = hop_out_reg;
        status_next  = status_reg;

        cmd_ready     = 1'b0;
        res_valid     = 1'b0;
        ram_req.wr_en = 1'b0;
        ram_req.rd_en = 1'b0;
        ram_req.addr  = walk_addr;
        ram_req.wdata = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the pool to empty entries
                ram_req.wr_en = 1'b1;
                ram_req.addr  = clr_reg;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next      = cmd.opcode;
                    addr_next    = cmd.address;
                    depth_next   = cmd_depth;
                    level_next   = '0;
                    node_next    = '0;
                    hop_in_next  = cmd.hop_in;
                    hit_next     = 1'b0;
                    hop_out_next = '0;
                    status_next  = STAT_OK;
                    if (cmd.opcode == OP_INSERT && cmd_depth == '0)
                    begin
                        status_next = STAT_BAD_LEN;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                ram_req.rd_en = 1'b1;
                state_next    = S_EVAL;
            end

            S_EVAL:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    // Keep the deepest valid hop, stop at a leaf
                    if (ram_rdata.valid)
                    begin
                        hit_next     = 1'b1;
                        hop_out_next = ram_rdata.hop;
                    end
                    if (ram_rdata.child == '0 || level_reg == DEPTH_W'(LEVELS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        node_next  = ram_rdata.child;
                        level_next = level_reg + DEPTH_W'(1);
                        addr_next  = addr_reg << STRIDE;
                        state_next = S_READ;
                    end
                end
                else if (level_reg + DEPTH_W'(1) == depth_reg)
                begin
                    // Store the hop, keep the existing child link
                    ram_req.wr_en       = 1'b1;
                    ram_req.wdata.valid = 1'b1;
                    ram_req.wdata.hop   = hop_in_reg;
                    ram_req.wdata.child = ram_rdata.child;
                    state_next          = S_DONE;
                end
                else if (ram_rdata.child != '0)
                begin
                    node_next  = ram_rdata.child;
                    level_next = level_reg + DEPTH_W'(1);
                    addr_next  = addr_reg << STRIDE;
                    state_next = S_READ;
                end
                else if (need_total > (FREE_W + 1)'(NODES))
                begin
                    status_next = STAT_POOL_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    // Allocate the next free node and link it
                    ram_req.wr_en       = 1'b1;
                    ram_req.wdata.valid = ram_rdata.valid;
                    ram_req.wdata.hop   = ram_rdata.hop;
                    ram_req.wdata.child = free_reg[CHILD_W-1:0];
                    node_next           = free_reg[CHILD_W-1:0];
                    free_next           = free_reg + FREE_W'(1);
                    level_next          = level_reg + DEPTH_W'(1);
                    addr_next           = addr_reg << STRIDE;
                    state_next          = S_READ;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.hit     = hit_reg;
    assign res.hop_out = hop_out_reg;
    assign res.status  = status_reg;

endmodule

[hdl/multibit_trie_prefix_lookup.sv]
// ============================================================================
// multibit_trie_prefix_lookup
// IPv4 longest-prefix match over a fixed-stride multibit trie node pool.
// ============================================================================
// Usage:
//   s_axis carries one command per transfer: tuser is the opcode (insert or
//   lookup), tdata holds address, prefix_len and hop_in. m_axis returns
//   exactly one result per command: hit, hop_out and status in tdata.
//   Each trie level costs one node pool read plus one evaluate step; an insert
//   with a rejected prefix length skips the walk and goes straight to its
//   result. The pool is single-port, so one item is worked on at a time; the
//   next command is taken once the last result is handed to the output register.
//   Insert writes (child link or hop) share the evaluate cycle of a level.
//   After reset the pool is swept to empty entries, one entry per cycle,
//   all NODES * 2^STRIDE = 65536 entries, with s_axis_tready low throughout.
//   Results sit in an output register; while m_axis is stalled one finished
//   result waits there and the next command may still be taken and run,
//   then held in the engine until the register frees up.
// ============================================================================
module multibit_trie_prefix_lookup
    import mbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] address, [37:32] prefix_len, [69:38] hop_in, [71:70] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] hit, [32:1] hop_out, [34:33] status, [39:35] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cmd_t     cmd;
    res_t     eng_res;
    logic     eng_ready;
    logic     eng_done;
    logic     out_ready;
    ram_req_t ram_req;
    entry_t   ram_rdata;
    logic     m_valid_reg, m_valid_next;
    res_t     m_res_reg, m_res_next;

    // Unpack the command
    assign cmd.opcode     = op_t'(s_axis_tuser);
    assign cmd.address    = s_axis_tdata[31:0];
    assign cmd.prefix_len = s_axis_tdata[37:32];
    assign cmd.hop_in     = s_axis_tdata[69:38];

    mbt_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd       (cmd),
        .cmd_ready (eng_ready),
        .res_valid (eng_done),
        .res       (eng_res),
        .res_ready (out_ready),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    mbt_node_ram u_node_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = eng_ready;

    // Output register: load when empty or being drained
    assign out_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (out_ready)
        begin
            m_valid_next = eng_done;
            if (eng_done)
            begin
                m_res_next = eng_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_res_reg.status, m_res_reg.hop_out, m_res_reg.hit};

    // Engine never takes a command while a result is pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(eng_ready && eng_done))
        else $error("engine ready while holding a result");

    // A result handed over always shows up on m_axis next cycle
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_done && out_ready) |=> m_axis_tvalid)
        else $error("result lost between engine and output register");

    // A hit only comes with an ok status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[34:33] == STAT_OK))
        else $error("hit reported with error status");

    // No undefined status code leaves the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:33] != 2'b11))
        else $error("undefined status code");

endmodule

[verif/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the multibit trie longest-prefix-match engine.
// A scoreboard keeps its own node pool and predicts each command's result;
// directed commands cover empty lookups, bad lengths, all depths, all-zero
// and all-one fields and hop overwrite. Random traffic then builds on known
// prefixes, fills the node pool and keeps looking up under random stalls.
// ============================================================================
module tb;
    import mbt_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 430;
    localparam int unsigned STALL_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 150;

    // Reference trie: pool of nodes, one result expected per command
    class lpm_scoreboard;
        bit          pool_valid [MEM_DEPTH];
        logic [31:0] pool_hop   [MEM_DEPTH];
        int unsigned pool_child [MEM_DEPTH];
        int unsigned nodes_used;
        res_t        pending_results [$];
        int unsigned errors;
        int unsigned commands;

        function new();
            foreach (pool_hop[i])
            begin
                pool_valid[i] = 1'b0;
                pool_hop[i]   = '0;
                pool_child[i] = 0;
            end
            nodes_used = 1;
            errors     = 0;
            commands   = 0;
        endfunction

        function int unsigned entry_of(int unsigned node, logic [31:0] addr,
                                       int unsigned lvl);
            return node * FANOUT + ((addr >> (32 - (lvl + 1) * STRIDE)) & (FANOUT - 1));
        endfunction

        function status_t insert_prefix(logic [31:0] addr, logic [5:0] plen,
                                        logic [31:0] hop);
            int unsigned depth;
            int unsigned node;
            int unsigned e;
            int unsigned needed;
            if (plen == 0 || plen % STRIDE != 0 || plen > LEVELS * STRIDE)
            begin
                return STAT_BAD_LEN;
            end
            depth  = plen / STRIDE;
            node   = 0;
            needed = 0;
            // Count the nodes this prefix still lacks
            for (int unsigned lvl = 0; lvl + 1 < depth; lvl++)
            begin
                e = entry_of(node, addr, lvl);
                if (pool_child[e] == 0)
                begin
                    needed = depth - 1 - lvl;
                    break;
                end
                node = pool_child[e];
            end
            if (nodes_used + needed > NODES)
            begin
                return STAT_POOL_FULL;
            end
            // Walk down again, link new nodes and store the hop
            node = 0;
            for (int unsigned lvl = 0; lvl + 1 < depth; lvl++)
            begin
                e = entry_of(node, addr, lvl);
                if (pool_child[e] == 0)
                begin
                    pool_child[e] = nodes_used;
                    nodes_used++;
                end
                node = pool_child[e];
            end
            e = entry_of(node, addr, depth - 1);
            pool_valid[e] = 1'b1;
            pool_hop[e]   = hop;
            return STAT_OK;
        endfunction

        function res_t longest_match(logic [31:0] addr);
            res_t        r;
            int unsigned node;
            int unsigned e;
            r.hit     = 1'b0;
            r.hop_out = '0;
            r.status  = STAT_OK;
            node      = 0;
            for (int unsigned lvl = 0; lvl < LEVELS; lvl++)
            begin
                e = entry_of(node, addr, lvl);
                if (pool_valid[e])
                begin
                    r.hit     = 1'b1;
                    r.hop_out = pool_hop[e];
                end
                if (pool_child[e] == 0)
                begin
                    break;
                end
                node = pool_child[e];
            end
            return r;
        endfunction

        function void note_command(cmd_t c);
            res_t r;
            if (c.opcode == OP_INSERT)
            begin
                r.hit     = 1'b0;
                r.hop_out = '0;
                r.status  = insert_prefix(c.address, c.prefix_len, c.hop_in);
            end
            else
            begin
                r = longest_match(c.address);
            end
            pending_results.push_back(r);
            commands++;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no command outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (data[0] !== want.hit)
            begin
                $error("hit mismatch: expected %b, actual %b", want.hit, data[0]);
                errors++;
            end
            if (data[32:1] !== want.hop_out)
            begin
                $error("hop_out mismatch: expected %h, actual %h", want.hop_out, data[32:1]);
                errors++;
            end
            if (data[34:33] !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, data[34:33]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    lpm_scoreboard sb = new();

    // Prefixes issued so far, reused to build matching traffic
    logic [31:0] known_addr [$];
    logic [5:0]  known_len  [$];
    int unsigned burst_left = 0;

    multibit_trie_prefix_lookup dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] prefix_mask(input int unsigned plen);
        return ~(32'hFFFF_FFFF >> plen);
    endfunction

    // Offer one command until the transfer, then pause between bursts
    task automatic send_cmd(input op_t op, input logic [31:0] addr,
                            input logic [5:0] plen, input logic [31:0] hop);
        cmd_t c;
        c.opcode     = op;
        c.address    = addr;
        c.prefix_len = plen;
        c.hop_in     = hop;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, hop, plen, addr};
        s_axis_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_command(c);
        if (op == OP_INSERT && plen != 0 && plen % STRIDE == 0 && plen <= 32)
        begin
            known_addr.push_back(addr);
            known_len.push_back(plen);
        end
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Stimulus and final verdict
    initial
    begin
        int unsigned pick;
        int unsigned sel;
        int unsigned k;
        logic [31:0] addr;
        logic [31:0] hop;
        logic [31:0] mask;
        logic [5:0]  plen;
        op_t         op;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, bad lengths
        send_cmd(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
        send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 32'h0A00_0000, 6'd0, 32'h1111_1111);
        send_cmd(OP_INSERT, 32'h0A00_0000, 6'd12, 32'h2222_2222);
        send_cmd(OP_INSERT, 32'h0A00_0000, 6'd31, 32'h3333_3333);
        // One prefix per depth along the same path
        send_cmd(OP_INSERT, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0001);
        send_cmd(OP_INSERT, 32'h0A01_0200, 6'd24, 32'h0000_0002);
        send_cmd(OP_INSERT, 32'h0A01_0203, 6'd32, 32'h0000_0000);
        send_cmd(OP_LOOKUP, 32'h0A01_0203, 6'd5, 32'h0);
        send_cmd(OP_LOOKUP, 32'h0A01_0204, 6'd0, 32'h0);
        send_cmd(OP_LOOKUP, 32'h0A02_0000, 6'd0, 32'h0);
        send_cmd(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
        // Deep prefix with no shorter ones on its path
        send_cmd(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hA5A5_A5A5);
        send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
        send_cmd(OP_LOOKUP, 32'hFFFF_FF00, 6'd0, 32'h0);
        // Overwrite an existing hop
        send_cmd(OP_INSERT, 32'h0A01_0200, 6'd24, 32'h1234_5678);
        send_cmd(OP_LOOKUP, 32'h0A01_02FF, 6'd0, 32'h0);
        // All-zero address and a top-bit prefix
        send_cmd(OP_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000);
        send_cmd(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
        send_cmd(OP_INSERT, 32'h8000_0000, 6'd8, 32'h7FFF_FFFF);
        send_cmd(OP_LOOKUP, 32'h80FF_FFFF, 6'd0, 32'h0);

        // Random traffic: builds on known prefixes, then fills the pool
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            hop  = $urandom();
            if (i >= 150 && sb.nodes_used < NODES && pick < 30)
            begin
                op   = OP_INSERT;
                addr = $urandom();
                plen = 6'd32;
            end
            else if (pick < 45)
            begin
                op   = OP_INSERT;
                plen = (sel < 2) ? 6'($urandom_range(0, 32))
                                 : 6'(STRIDE * $urandom_range(1, LEVELS));
                addr = $urandom();
                k    = $urandom_range(0, known_addr.size() - 1);
                if (sel == 2)
                begin
                    addr = known_addr[k];
                    plen = known_len[k];
                end
                else if (sel < 6)
                begin
                    mask = prefix_mask(STRIDE * $urandom_range(1, LEVELS - 1));
                    addr = (known_addr[k] & mask) | ($urandom() & ~mask);
                end
            end
            else
            begin
                op   = OP_LOOKUP;
                addr = $urandom();
                plen = 6'($urandom_range(0, 32));
                if (pick < 88)
                begin
                    k    = $urandom_range(0, known_addr.size() - 1);
                    mask = prefix_mask(known_len[k]);
                    addr = (known_addr[k] & mask) | (addr & ~mask);
                end
            end
            send_cmd(op, addr, plen, hop);
        end

        // Drain and decide
        if (burst_left != 0)
        begin
            s_axis_tvalid <= 1'b0;
        end
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result side: stall patterns plus one long hold-off
    initial
    begin
        int unsigned mode;
        int unsigned stretch;
        bit          held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sb.commands >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(16, 96);
            repeat (stretch)
            begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Check each result transfer
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: end the run after a long stretch with no transfer
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule
